[rtl/urr_pkg.sv]
package urr_pkg;

    localparam int HORIZON_STEPS   = 10;
    localparam int STEP_W          = 4;
    localparam int POSE_W          = 24;
    localparam int SPEED_W         = 16;
    localparam int TURN_W          = 16;
    localparam int CFG_ADDR_W      = 3;
    localparam int TRIG_W          = 34;
    localparam int ANG_W           = 20;
    localparam int WRAP_W          = 26;
    localparam int MUL_A_W         = 34;
    localparam int MUL_B_W         = 31;
    localparam int PROD_W          = MUL_A_W + MUL_B_W;
    localparam int VT_W            = 30;
    localparam int RND_W           = 26;
    localparam int SUM_W           = 27;
    localparam int CORDIC_ITERS    = 16;
    localparam int ITER_W          = 4;
    localparam int WRAP_STEPS      = 7;
    localparam int WRAP_K_W        = 3;

    localparam int TENTH_Q16       = 6554;
    localparam int PI_Q16          = 205887;
    localparam int HALF_PI_Q16     = 102944;
    localparam int TWO_PI_Q16      = 411775;
    localparam int CORDIC_GAIN_Q30 = 652032874;

    localparam int SHIFT_DISP      = 41;
    localparam int SHIFT_HEAD      = 14;
    localparam int SHIFT_ERR       = 16;

    localparam logic signed [SUM_W-1:0] WRAP_BIAS = SUM_W'(PI_Q16 + 64 * TWO_PI_Q16);
    localparam logic signed [SUM_W-1:0] SAT_HI    = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] SAT_LO    = -SUM_W'(8388608);

    typedef logic signed [POSE_W-1:0] pose_t;
    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ANG_W-1:0]  ang_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_START_X       = 3'd0,
        REG_START_Y       = 3'd1,
        REG_START_HEADING = 3'd2,
        REG_GOAL_X        = 3'd3,
        REG_GOAL_Y        = 3'd4,
        REG_GOAL_HEADING  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic  start;
        pose_t angle;
    } cordic_req_t;

    typedef struct packed {
        logic  done;
        trig_t cos_val;
        trig_t sin_val;
    } cordic_rsp_t;

    function automatic ang_t atan_q16(input logic [ITER_W-1:0] i);
        ang_t r;
        case (i)
            4'd0:    r = ANG_W'(51472);
            4'd1:    r = ANG_W'(30386);
            4'd2:    r = ANG_W'(16055);
            4'd3:    r = ANG_W'(8150);
            4'd4:    r = ANG_W'(4091);
            4'd5:    r = ANG_W'(2047);
            4'd6:    r = ANG_W'(1024);
            4'd7:    r = ANG_W'(512);
            4'd8:    r = ANG_W'(256);
            4'd9:    r = ANG_W'(128);
            4'd10:   r = ANG_W'(64);
            4'd11:   r = ANG_W'(32);
            4'd12:   r = ANG_W'(16);
            4'd13:   r = ANG_W'(8);
            4'd14:   r = ANG_W'(4);
            default: r = ANG_W'(2);
        endcase
        return r;
    endfunction

    function automatic logic signed [RND_W-1:0] round_shift(input prod_t p,
                                                           input int unsigned s);
        prod_t r;
        r = (p + (prod_t'(1) <<< (s - 1))) >>> s;
        return r[RND_W-1:0];
    endfunction

    function automatic pose_t sat24(input logic signed [SUM_W-1:0] v);
        pose_t r;
        if (v > SAT_HI) begin
            r = SAT_HI[POSE_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[POSE_W-1:0];
        end else begin
            r = v[POSE_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/urr_mul.sv]
module urr_mul (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [urr_pkg::MUL_A_W-1:0]  op_a,
    input  logic signed [urr_pkg::MUL_B_W-1:0]  op_b,
    output urr_pkg::prod_t                      prod
);

    urr_pkg::prod_t prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

[rtl/urr_cordic.sv]
module urr_cordic (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  urr_pkg::cordic_req_t req,
    output urr_pkg::cordic_rsp_t rsp
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_WRAP,
        C_FOLD,
        C_ROT
    } cstate_t;

    cstate_t                          state_reg, state_next;
    logic [urr_pkg::WRAP_W-1:0]       t_reg, t_next;
    logic [urr_pkg::WRAP_K_W-1:0]     k_reg, k_next;
    logic [urr_pkg::ITER_W-1:0]       i_reg, i_next;
    urr_pkg::trig_t                   x_reg, x_next;
    urr_pkg::trig_t                   y_reg, y_next;
    urr_pkg::ang_t                    z_reg, z_next;
    logic                             flip_reg, flip_next;
    logic                             done_reg, done_next;
    urr_pkg::trig_t                   cos_reg, cos_next;
    urr_pkg::trig_t                   sin_reg, sin_next;

    logic signed [urr_pkg::SUM_W-1:0] t_init;
    logic [urr_pkg::WRAP_W-1:0]       cand;
    logic signed [urr_pkg::SUM_W-1:0] z_wide;
    urr_pkg::ang_t                    z0;
    urr_pkg::trig_t                   xs, ys, x_rot, y_rot;
    urr_pkg::ang_t                    z_rot;

    localparam urr_pkg::ang_t PI_A   = urr_pkg::ANG_W'(urr_pkg::PI_Q16);
    localparam urr_pkg::ang_t HALF_A = urr_pkg::ANG_W'(urr_pkg::HALF_PI_Q16);

    always_comb begin
        state_next = state_reg;
        t_next     = t_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        flip_next  = flip_reg;
        done_next  = 1'b0;
        cos_next   = cos_reg;
        sin_next   = sin_reg;

        t_init = urr_pkg::SUM_W'(req.angle) + urr_pkg::WRAP_BIAS;
        cand   = urr_pkg::WRAP_W'(urr_pkg::TWO_PI_Q16) << k_reg;
        z_wide = $signed({1'b0, t_reg}) - urr_pkg::SUM_W'(urr_pkg::PI_Q16);
        z0     = z_wide[urr_pkg::ANG_W-1:0];
        xs     = x_reg >>> i_reg;
        ys     = y_reg >>> i_reg;
        if (!z_reg[urr_pkg::ANG_W-1]) begin
            x_rot = x_reg - ys;
            y_rot = y_reg + xs;
            z_rot = z_reg - urr_pkg::atan_q16(i_reg);
        end else begin
            x_rot = x_reg + ys;
            y_rot = y_reg - xs;
            z_rot = z_reg + urr_pkg::atan_q16(i_reg);
        end

        unique case (state_reg)
            C_IDLE: begin
                if (req.start) begin
                    t_next     = t_init[urr_pkg::WRAP_W-1:0];
                    k_next     = urr_pkg::WRAP_K_W'(urr_pkg::WRAP_STEPS - 1);
                    state_next = C_WRAP;
                end
            end
            C_WRAP: begin
                if (t_reg >= cand) begin
                    t_next = t_reg - cand;
                end
                if (k_reg == '0) begin
                    state_next = C_FOLD;
                end else begin
                    k_next = k_reg - 1'b1;
                end
            end
            C_FOLD: begin
                if (z0 > HALF_A) begin
                    z_next    = PI_A - z0;
                    flip_next = 1'b1;
                end else if (z0 < -HALF_A) begin
                    z_next    = -PI_A - z0;
                    flip_next = 1'b1;
                end else begin
                    z_next    = z0;
                    flip_next = 1'b0;
                end
                x_next     = urr_pkg::TRIG_W'(urr_pkg::CORDIC_GAIN_Q30);
                y_next     = '0;
                i_next     = '0;
                state_next = C_ROT;
            end
            C_ROT: begin
                x_next = x_rot;
                y_next = y_rot;
                z_next = z_rot;
                if (i_reg == urr_pkg::ITER_W'(urr_pkg::CORDIC_ITERS - 1)) begin
                    cos_next   = flip_reg ? -x_rot : x_rot;
                    sin_next   = y_rot;
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        t_reg    <= t_next;
        k_reg    <= k_next;
        i_reg    <= i_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.cos_val = cos_reg;
    assign rsp.sin_val = sin_reg;

endmodule

[rtl/unicycle_rollout_residual.sv]
// Unicycle rollout residual.
// Configure start and goal pose on the cfg channel (index 0..5: start x, y,
// heading, goal x, y, heading; other indexes are dropped) while idle.
// Each s_ beat is one control sample (speed, turn rate) and advances the pose
// by one Euler step of 0.1. The first beat of a rollout reloads the start pose.
// After HORIZON_STEPS beats one m_ beat carries 0.1 times the pose error.
// Each beat's time is set by the CORDIC unit (7 range
// reduction steps, one fold and 16 rotations) followed by two products and a
// pose update on the shared multiplier. The closing beat of a rollout then
// forms the three error products and registers them behind m_tvalid.
// s_tready is high only while idle. The result sits in an output register,
// so the next rollout runs while it waits; if a second result is ready
// before the first is taken, the block holds until m_tready drains it.
// Reset clears the configuration to zero, the step count and m_tvalid.
module unicycle_rollout_residual (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // speed[15:0], turn_rate[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // error_x[23:0], error_y[47:24], error_heading[71:48]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MULV,
        S_MULW,
        S_HUPD,
        S_WAITC,
        S_MULX,
        S_MULY,
        S_UPD,
        S_ERRW,
        S_ERRX,
        S_ERRY,
        S_ERRH,
        S_ERRL
    } state_t;

    state_t                            state_reg, state_next;
    logic [urr_pkg::STEP_W-1:0]        step_reg, step_next;
    urr_pkg::pose_t                    start_x_reg, start_x_next;
    urr_pkg::pose_t                    start_y_reg, start_y_next;
    urr_pkg::pose_t                    start_h_reg, start_h_next;
    urr_pkg::pose_t                    goal_x_reg, goal_x_next;
    urr_pkg::pose_t                    goal_y_reg, goal_y_next;
    urr_pkg::pose_t                    goal_h_reg, goal_h_next;
    urr_pkg::pose_t                    pose_x_reg, pose_x_next;
    urr_pkg::pose_t                    pose_y_reg, pose_y_next;
    urr_pkg::pose_t                    pose_h_reg, pose_h_next;
    logic [urr_pkg::SPEED_W-1:0]       speed_reg, speed_next;
    logic signed [urr_pkg::TURN_W-1:0] turn_reg, turn_next;
    logic [urr_pkg::VT_W-1:0]          vt_reg, vt_next;
    urr_pkg::pose_t                    ex_reg, ex_next;
    urr_pkg::pose_t                    ey_reg, ey_next;
    urr_pkg::pose_t                    eh_reg, eh_next;
    logic                              m_tvalid_reg, m_tvalid_next;

    urr_pkg::cordic_req_t              creq;
    urr_pkg::cordic_rsp_t              crsp;
    logic                              mul_en;
    logic signed [urr_pkg::MUL_A_W-1:0] mul_a;
    logic signed [urr_pkg::MUL_B_W-1:0] mul_b;
    urr_pkg::prod_t                    prod;
    logic signed [urr_pkg::POSE_W:0]   diff_x, diff_y, diff_h;
    logic                              s_accept;

    localparam logic signed [urr_pkg::MUL_B_W-1:0] TENTH_B =
        urr_pkg::MUL_B_W'(urr_pkg::TENTH_Q16);

    urr_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .rsp     (crsp)
    );

    urr_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign diff_x    = (urr_pkg::POSE_W + 1)'(pose_x_reg) - (urr_pkg::POSE_W + 1)'(goal_x_reg);
    assign diff_y    = (urr_pkg::POSE_W + 1)'(pose_y_reg) - (urr_pkg::POSE_W + 1)'(goal_y_reg);
    assign diff_h    = (urr_pkg::POSE_W + 1)'(pose_h_reg) - (urr_pkg::POSE_W + 1)'(goal_h_reg);

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        start_x_next  = start_x_reg;
        start_y_next  = start_y_reg;
        start_h_next  = start_h_reg;
        goal_x_next   = goal_x_reg;
        goal_y_next   = goal_y_reg;
        goal_h_next   = goal_h_reg;
        pose_x_next   = pose_x_reg;
        pose_y_next   = pose_y_reg;
        pose_h_next   = pose_h_reg;
        speed_next    = speed_reg;
        turn_next     = turn_reg;
        vt_next       = vt_reg;
        ex_next       = ex_reg;
        ey_next       = ey_reg;
        eh_next       = eh_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        creq.start    = 1'b0;
        creq.angle    = (step_reg == '0) ? start_h_reg : pose_h_reg;
        mul_en        = 1'b0;
        mul_a         = '0;
        mul_b         = TENTH_B;

        if (cfg_valid) begin
            unique case (urr_pkg::cfg_reg_t'(cfg_addr))
                urr_pkg::REG_START_X:       start_x_next = cfg_data;
                urr_pkg::REG_START_Y:       start_y_next = cfg_data;
                urr_pkg::REG_START_HEADING: start_h_next = cfg_data;
                urr_pkg::REG_GOAL_X:        goal_x_next  = cfg_data;
                urr_pkg::REG_GOAL_Y:        goal_y_next  = cfg_data;
                urr_pkg::REG_GOAL_HEADING:  goal_h_next  = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    speed_next = s_tdata[15:0];
                    turn_next  = s_tdata[31:16];
                    creq.start = 1'b1;
                    if (step_reg == '0) begin
                        pose_x_next = start_x_reg;
                        pose_y_next = start_y_reg;
                        pose_h_next = start_h_reg;
                    end
                    state_next = S_MULV;
                end
            end
            S_MULV: begin
                mul_en     = 1'b1;
                mul_a      = $signed({{(urr_pkg::MUL_A_W - urr_pkg::SPEED_W){1'b0}}, speed_reg});
                state_next = S_MULW;
            end
            S_MULW: begin
                vt_next    = prod[urr_pkg::VT_W-1:0];
                mul_en     = 1'b1;
                mul_a      = urr_pkg::MUL_A_W'(turn_reg);
                state_next = S_HUPD;
            end
            S_HUPD: begin
                pose_h_next = urr_pkg::sat24(urr_pkg::SUM_W'(pose_h_reg)
                    + urr_pkg::SUM_W'(urr_pkg::round_shift(prod, urr_pkg::SHIFT_HEAD)));
                state_next  = S_WAITC;
            end
            S_WAITC: begin
                if (crsp.done) begin
                    state_next = S_MULX;
                end
            end
            S_MULX: begin
                mul_en     = 1'b1;
                mul_a      = crsp.cos_val;
                mul_b      = $signed({1'b0, vt_reg});
                state_next = S_MULY;
            end
            S_MULY: begin
                pose_x_next = urr_pkg::sat24(urr_pkg::SUM_W'(pose_x_reg)
                    + urr_pkg::SUM_W'(urr_pkg::round_shift(prod, urr_pkg::SHIFT_DISP)));
                mul_en      = 1'b1;
                mul_a       = crsp.sin_val;
                mul_b       = $signed({1'b0, vt_reg});
                state_next  = S_UPD;
            end
            S_UPD: begin
                pose_y_next = urr_pkg::sat24(urr_pkg::SUM_W'(pose_y_reg)
                    + urr_pkg::SUM_W'(urr_pkg::round_shift(prod, urr_pkg::SHIFT_DISP)));
                if (step_reg == urr_pkg::STEP_W'(urr_pkg::HORIZON_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = S_ERRW;
                end else begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ERRW: begin
                if (!m_tvalid_reg) begin
                    state_next = S_ERRX;
                end
            end
            S_ERRX: begin
                mul_en     = 1'b1;
                mul_a      = urr_pkg::MUL_A_W'(diff_x);
                state_next = S_ERRY;
            end
            S_ERRY: begin
                ex_next    = urr_pkg::sat24(urr_pkg::SUM_W'(
                    urr_pkg::round_shift(prod, urr_pkg::SHIFT_ERR)));
                mul_en     = 1'b1;
                mul_a      = urr_pkg::MUL_A_W'(diff_y);
                state_next = S_ERRH;
            end
            S_ERRH: begin
                ey_next    = urr_pkg::sat24(urr_pkg::SUM_W'(
                    urr_pkg::round_shift(prod, urr_pkg::SHIFT_ERR)));
                mul_en     = 1'b1;
                mul_a      = urr_pkg::MUL_A_W'(diff_h);
                state_next = S_ERRL;
            end
            S_ERRL: begin
                eh_next       = urr_pkg::sat24(urr_pkg::SUM_W'(
                    urr_pkg::round_shift(prod, urr_pkg::SHIFT_ERR)));
                m_tvalid_next = 1'b1;
                state_next    = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            start_x_reg  <= '0;
            start_y_reg  <= '0;
            start_h_reg  <= '0;
            goal_x_reg   <= '0;
            goal_y_reg   <= '0;
            goal_h_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            start_x_reg  <= start_x_next;
            start_y_reg  <= start_y_next;
            start_h_reg  <= start_h_next;
            goal_x_reg   <= goal_x_next;
            goal_y_reg   <= goal_y_next;
            goal_h_reg   <= goal_h_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        pose_x_reg <= pose_x_next;
        pose_y_reg <= pose_y_next;
        pose_h_reg <= pose_h_next;
        speed_reg  <= speed_next;
        turn_reg   <= turn_next;
        vt_reg     <= vt_next;
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
        eh_reg     <= eh_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {eh_reg, ey_reg, ex_reg};

endmodule

[rtl/urr_checker.sv]
module urr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // busy after a sample beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a step is in progress");

    // come out of reset idle with no result
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

    // a result only appears at the end of a rollout
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised while idle");

endmodule

bind unicycle_rollout_residual urr_checker u_urr_checker (.*);
